/* sv/nirq_pkg.sv */
// Package for the network impairment release queue: sizes, codes, types and states.
package nirq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PEER_COUNT    = 64;
    localparam int CHANNEL_COUNT = 8;
    localparam int MAX_OUT       = 16;

    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int PW   = $clog2(PEER_COUNT);
    localparam int CW   = $clog2(CHANNEL_COUNT);
    localparam int KW   = PW + CW;
    localparam int KEYS = PEER_COUNT * CHANNEL_COUNT;
    localparam int TW   = 48;

    localparam logic [2:0] CMD_ADMIT      = 3'd0;
    localparam logic [2:0] CMD_DRAIN      = 3'd1;
    localparam logic [2:0] CMD_PEER_BLOCK = 3'd2;
    localparam logic [2:0] CMD_FORGET     = 3'd3;
    localparam logic [2:0] CMD_ALL_BLOCK  = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    localparam logic [2:0] STS_PASS      = 3'd0;
    localparam logic [2:0] STS_DROP_BLK  = 3'd1;
    localparam logic [2:0] STS_DROP_LOSS = 3'd2;
    localparam logic [2:0] STS_HELD      = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;
    localparam logic [2:0] STS_RELEASED  = 3'd5;
    localparam logic [2:0] STS_DONE      = 3'd6;

    localparam logic [1:0] REG_LATENCY = 2'd0;
    localparam logic [1:0] REG_JITTER  = 2'd1;
    localparam logic [1:0] REG_LOSS    = 2'd2;

    localparam logic [1:0] MODE_UNRELIABLE = 2'd0;

    typedef struct packed {
        logic          vld;
        logic [TW-1:0] tm;
    } chan_entry_t;

    typedef struct packed {
        logic [15:0]   tag;
        logic [1:0]    mode;
        logic [2:0]    chan;
        logic [PW-1:0] peer;
    } slot_det_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SUM,
        ST_ORDER,
        ST_INSERT,
        ST_SCAN,
        ST_PURGE,
        ST_FORGET_CH,
        ST_EMIT,
        ST_COMPACT
    } st_t;

endpackage

/* sv/network_impairment_release_queue_unit.sv */
// Top level of the network impairment release queue: sequencer, sorted queue and counters.
//
//   channel | handshake               | payload
//   in      | in_valid / in_stall     | command, peer, channel, transfer_mode, enable, now_ms,
//           |                         | loss_sample, jitter_sample, packet_tag
//   out     | out_valid / out_stall   | status, out_peer .. release_ms, last, counters, active
//   cfg     | cfg_write               | cfg_index, cfg_data
//
// One item at a time. Admit decides in ST_DECIDE; a held packet passes ST_SUM, ST_ORDER
// (reliable modes only) and ST_INSERT, which shifts each later queued entry up one slot.
// Drain: ST_SCAN finds due entries, ST_EMIT releases them and ST_COMPACT closes up the rest.
// Peer blackout (if enabled) and forget purge the peer's entries; forget clears its channel times.
// Global blackout (if enabled), clear queue and reset sweep all 512 channel-time memory entries.
// in_stall is high whenever the sequencer is busy; a stalled result holds its payload.
module network_impairment_release_queue_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [16:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              command,
    input  logic [5:0]              peer,
    input  logic [2:0]              channel,
    input  logic [1:0]              transfer_mode,
    input  logic                    enable,
    input  logic [47:0]             now_ms,
    input  logic [15:0]             loss_sample,
    input  logic [15:0]             jitter_sample,
    input  logic [15:0]             packet_tag,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              status,
    output logic [5:0]              out_peer,
    output logic [2:0]              out_channel,
    output logic [1:0]              out_mode,
    output logic [15:0]             out_tag,
    output logic [47:0]             release_ms,
    output logic                    last,
    output logic [31:0]             dropped_out_count,
    output logic [31:0]             dropped_in_count,
    output logic [31:0]             delayed_count,
    output logic [4:0]              queued_count,
    output logic                    active
);
    import nirq_pkg::*;

    st_t               state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [PW-1:0]     peer_reg, peer_next;
    logic [TW-1:0]     now_reg, now_next;
    logic [15:0]       lsamp_reg, lsamp_next;
    logic [15:0]       jsamp_reg, jsamp_next;
    slot_det_t         det_reg, det_next;
    logic [15:0]       latency_reg;
    logic [15:0]       jitter_reg;
    logic [16:0]       loss_reg;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [31:0]       dropped_reg, dropped_next;
    logic [31:0]       delayed_reg, delayed_next;
    logic              all_blk_reg, all_blk_next;
    logic [PEER_COUNT-1:0] peer_blk_reg, peer_blk_next;
    logic [FW-1:0]     ptr_reg, ptr_next;
    logic [FW-1:0]     w_reg, w_next;
    logic [FW-1:0]     due_reg, due_next;
    logic [31:0]       prod_reg, prod_next;
    logic [TW-1:0]     t_reg, t_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [TW-1:0]     res_rel_reg, res_rel_next;
    logic              drain_reg, drain_next;
    logic [KW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              clr_emit_reg, clr_emit_next;

    logic              out_vld_reg, out_vld_next;
    logic [2:0]        status_reg, status_next;
    slot_det_t         out_det_reg, out_det_next;
    logic [TW-1:0]     rel_reg, rel_next;
    logic              last_reg, last_next;
    logic [FW-1:0]     queued_reg, queued_next;
    logic              active_reg, active_next;

    logic [TW-1:0]     slot_time_reg [QUEUE_DEPTH];
    slot_det_t         slot_det_reg  [QUEUE_DEPTH];

    logic              wr_en;
    logic [FW-1:0]     wr_idx;
    logic [TW-1:0]     wr_time;
    slot_det_t         wr_det;

    logic [FW-1:0]     rd_idx;
    logic [TW-1:0]     rd_time;
    slot_det_t         rd_det;

    logic              mem_we;
    logic [KW-1:0]     mem_waddr;
    chan_entry_t       mem_wdata;
    logic              mem_re;
    logic [KW-1:0]     mem_raddr;
    chan_entry_t       mem_rdata;

    logic              in_xfer;
    logic              out_xfer;
    logic              blocked;
    logic              lossy;
    logic              nodelay;
    logic              full;
    logic              ins_move;
    logic              scan_hit;
    logic [FW-1:0]     rest;
    logic              compact_more;
    logic              purge_more;
    logic              keep;
    logic [TW:0]       sum;
    logic [TW-1:0]     t_sum;
    logic [TW-1:0]     ord_t;
    logic              clr_done;
    logic              fgt_done;
    logic [FW-1:0]     q_final;

    nirq_chan_mem u_chan_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_vld_reg && !out_stall;

    always_comb
    begin
        unique case (state_reg)
            ST_INSERT:  rd_idx = ptr_reg - FW'(1);
            ST_COMPACT: rd_idx = ptr_reg + due_reg;
            default:    rd_idx = ptr_reg;
        endcase
    end

    assign rd_time = slot_time_reg[rd_idx[QW-1:0]];
    assign rd_det  = slot_det_reg[rd_idx[QW-1:0]];

    assign blocked  = all_blk_reg || peer_blk_reg[peer_reg];
    assign lossy    = (det_reg.mode == MODE_UNRELIABLE) && ({1'b0, lsamp_reg} < loss_reg);
    assign nodelay  = (latency_reg == 16'd0) && (jitter_reg == 16'd0);
    assign full     = (fill_reg >= FW'(QUEUE_DEPTH));
    assign ins_move = (ptr_reg != '0) && (rd_time > t_reg);
    assign scan_hit = (ptr_reg < fill_reg) && (int'(ptr_reg) < MAX_OUT) && (rd_time <= now_reg);
    assign rest     = fill_reg - due_reg;
    assign compact_more = (ptr_reg < rest);
    assign purge_more   = (ptr_reg < fill_reg);
    assign keep     = (rd_det.peer != peer_reg);
    assign sum      = (TW+1)'(now_reg) + (TW+1)'(latency_reg) + (TW+1)'(prod_reg[31:16]);
    assign t_sum    = sum[TW] ? '1 : sum[TW-1:0];
    assign ord_t    = (mem_rdata.vld && (mem_rdata.tm > t_reg)) ? mem_rdata.tm : t_reg;
    assign clr_done = (clr_cnt_reg == KW'(KEYS - 1));
    assign fgt_done = (clr_cnt_reg[CW-1:0] == CW'(CHANNEL_COUNT - 1));
    assign q_final  = drain_reg ? rest : fill_reg;

    assign mem_re    = (state_reg == ST_DECIDE);
    assign mem_raddr = {peer_reg, det_reg.chan[CW-1:0]};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_FORGET_CH:
            begin
                mem_we    = 1'b1;
                mem_waddr = {peer_reg, clr_cnt_reg[CW-1:0]};
            end
            ST_ORDER:
            begin
                mem_we        = 1'b1;
                mem_waddr     = {peer_reg, det_reg.chan[CW-1:0]};
                mem_wdata.vld = 1'b1;
                mem_wdata.tm  = ord_t;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = clr_emit_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (command)
                        CMD_ADMIT:      state_next = ST_DECIDE;
                        CMD_DRAIN:      state_next = ST_SCAN;
                        CMD_PEER_BLOCK: state_next = enable ? ST_PURGE : ST_EMIT;
                        CMD_FORGET:     state_next = ST_PURGE;
                        CMD_ALL_BLOCK:  state_next = enable ? ST_CLEAR : ST_EMIT;
                        CMD_CLEAR:      state_next = ST_CLEAR;
                        default:        state_next = ST_EMIT;
                    endcase
                end
            end
            ST_DECIDE:
            begin
                state_next = (blocked || lossy || nodelay || full) ? ST_EMIT : ST_SUM;
            end
            ST_SUM:
            begin
                state_next = (det_reg.mode != MODE_UNRELIABLE) ? ST_ORDER : ST_INSERT;
            end
            ST_ORDER:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                if (!ins_move)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (!scan_hit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_PURGE:
            begin
                if (!purge_more)
                begin
                    state_next = (cmd_reg == CMD_FORGET) ? ST_FORGET_CH : ST_EMIT;
                end
            end
            ST_FORGET_CH:
            begin
                if (fgt_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer && last_reg)
                begin
                    state_next = drain_reg ? ST_COMPACT : ST_IDLE;
                end
            end
            ST_COMPACT:
            begin
                if (!compact_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        peer_next       = peer_reg;
        now_next        = now_reg;
        lsamp_next      = lsamp_reg;
        jsamp_next      = jsamp_reg;
        det_next        = det_reg;
        fill_next       = fill_reg;
        dropped_next    = dropped_reg;
        delayed_next    = delayed_reg;
        all_blk_next    = all_blk_reg;
        peer_blk_next   = peer_blk_reg;
        ptr_next        = ptr_reg;
        w_next          = w_reg;
        due_next        = due_reg;
        prod_next       = prod_reg;
        t_next          = t_reg;
        res_status_next = res_status_reg;
        res_rel_next    = res_rel_reg;
        drain_next      = drain_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_emit_next   = clr_emit_reg;
        out_vld_next    = out_vld_reg;
        status_next     = status_reg;
        out_det_next    = out_det_reg;
        rel_next        = rel_reg;
        last_next       = last_reg;
        queued_next     = queued_reg;
        active_next     = active_reg;
        wr_en           = 1'b0;
        wr_idx          = ptr_reg;
        wr_time         = rd_time;
        wr_det          = rd_det;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + KW'(1);
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next        = command;
                    peer_next       = peer;
                    now_next        = now_ms;
                    lsamp_next      = loss_sample;
                    jsamp_next      = jitter_sample;
                    det_next.peer   = peer;
                    det_next.chan   = channel;
                    det_next.mode   = transfer_mode;
                    det_next.tag    = packet_tag;
                    res_status_next = STS_DONE;
                    res_rel_next    = '0;
                    drain_next      = 1'b0;
                    ptr_next        = '0;
                    w_next          = '0;
                    clr_cnt_next    = '0;
                    clr_emit_next   = 1'b1;
                    unique case (command)
                        CMD_PEER_BLOCK:
                        begin
                            peer_blk_next[peer] = enable;
                        end
                        CMD_FORGET:
                        begin
                            peer_blk_next[peer] = 1'b0;
                        end
                        CMD_ALL_BLOCK:
                        begin
                            all_blk_next = enable;
                            if (enable)
                            begin
                                fill_next = '0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            ST_DECIDE:
            begin
                prod_next = {16'd0, jsamp_reg} * {16'd0, jitter_reg};
                priority if (blocked)
                begin
                    res_status_next = STS_DROP_BLK;
                    dropped_next    = dropped_reg + 32'd1;
                end
                else if (lossy)
                begin
                    res_status_next = STS_DROP_LOSS;
                    dropped_next    = dropped_reg + 32'd1;
                end
                else if (nodelay)
                begin
                    res_status_next = STS_PASS;
                end
                else if (full)
                begin
                    res_status_next = STS_FULL;
                end
                else
                begin
                    res_status_next = res_status_reg;
                end
            end
            ST_SUM:
            begin
                t_next   = t_sum;
                ptr_next = fill_reg;
            end
            ST_ORDER:
            begin
                t_next = ord_t;
            end
            ST_INSERT:
            begin
                wr_en = 1'b1;
                if (ins_move)
                begin
                    ptr_next = ptr_reg - FW'(1);
                end
                else
                begin
                    wr_time         = t_reg;
                    wr_det          = det_reg;
                    fill_next       = fill_reg + FW'(1);
                    delayed_next    = delayed_reg + 32'd1;
                    res_status_next = STS_HELD;
                    res_rel_next    = t_reg;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    ptr_next = ptr_reg + FW'(1);
                end
                else
                begin
                    due_next   = ptr_reg;
                    drain_next = (ptr_reg != '0);
                    ptr_next   = '0;
                end
            end
            ST_PURGE:
            begin
                if (purge_more)
                begin
                    ptr_next = ptr_reg + FW'(1);
                    if (keep)
                    begin
                        wr_en  = 1'b1;
                        wr_idx = w_reg;
                        w_next = w_reg + FW'(1);
                    end
                end
                else
                begin
                    fill_next = w_reg;
                end
            end
            ST_FORGET_CH:
            begin
                clr_cnt_next = clr_cnt_reg + KW'(1);
            end
            ST_EMIT:
            begin
                if (!out_vld_reg)
                begin
                    out_vld_next = 1'b1;
                    queued_next  = q_final;
                    active_next  = (latency_reg != '0) || (jitter_reg != '0) || (loss_reg != '0)
                                   || all_blk_reg || (peer_blk_reg != '0) || (q_final != '0);
                    if (drain_reg)
                    begin
                        status_next  = STS_RELEASED;
                        out_det_next = rd_det;
                        rel_next     = rd_time;
                        last_next    = (ptr_reg == due_reg - FW'(1));
                    end
                    else
                    begin
                        status_next  = res_status_reg;
                        out_det_next = (cmd_reg == CMD_ADMIT) ? det_reg : '0;
                        rel_next     = res_rel_reg;
                        last_next    = 1'b1;
                    end
                end
                else if (!out_stall)
                begin
                    out_vld_next = 1'b0;
                    ptr_next     = last_reg ? '0 : ptr_reg + FW'(1);
                end
                else
                begin
                    out_vld_next = 1'b1;
                end
            end
            ST_COMPACT:
            begin
                if (compact_more)
                begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + FW'(1);
                end
                else
                begin
                    fill_next = rest;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_time_reg[wr_idx[QW-1:0]] <= wr_time;
            slot_det_reg[wr_idx[QW-1:0]]  <= wr_det;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg <= '0;
            jitter_reg  <= '0;
            loss_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LATENCY: latency_reg <= cfg_data[15:0];
                REG_JITTER:  jitter_reg  <= cfg_data[15:0];
                REG_LOSS:    loss_reg    <= cfg_data;
                default:     loss_reg    <= loss_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            fill_reg     <= '0;
            dropped_reg  <= '0;
            delayed_reg  <= '0;
            all_blk_reg  <= 1'b0;
            peer_blk_reg <= '0;
            ptr_reg      <= '0;
            w_reg        <= '0;
            due_reg      <= '0;
            drain_reg    <= 1'b0;
            clr_cnt_reg  <= '0;
            clr_emit_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            dropped_reg  <= dropped_next;
            delayed_reg  <= delayed_next;
            all_blk_reg  <= all_blk_next;
            peer_blk_reg <= peer_blk_next;
            ptr_reg      <= ptr_next;
            w_reg        <= w_next;
            due_reg      <= due_next;
            drain_reg    <= drain_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_emit_reg <= clr_emit_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        peer_reg       <= peer_next;
        now_reg        <= now_next;
        lsamp_reg      <= lsamp_next;
        jsamp_reg      <= jsamp_next;
        det_reg        <= det_next;
        prod_reg       <= prod_next;
        t_reg          <= t_next;
        res_status_reg <= res_status_next;
        res_rel_reg    <= res_rel_next;
        status_reg     <= status_next;
        out_det_reg    <= out_det_next;
        rel_reg        <= rel_next;
        last_reg       <= last_next;
        queued_reg     <= queued_next;
        active_reg     <= active_next;
    end

    assign out_valid         = out_vld_reg;
    assign status            = status_reg;
    assign out_peer          = out_det_reg.peer;
    assign out_channel       = out_det_reg.chan;
    assign out_mode          = out_det_reg.mode;
    assign out_tag           = out_det_reg.tag;
    assign release_ms        = rel_reg;
    assign last              = last_reg;
    assign dropped_out_count = dropped_reg;
    assign dropped_in_count  = '0;
    assign delayed_count     = delayed_reg;
    assign queued_count      = 5'(queued_reg);
    assign active            = active_reg;

endmodule

/* sv/nirq_chan_mem.sv */
// Per peer/channel last release time memory, one write and one registered read port.
module nirq_chan_mem (
    input  logic                  clk,
    input  logic                  we,
    input  logic [nirq_pkg::KW-1:0] waddr,
    input  nirq_pkg::chan_entry_t wdata,
    input  logic                  re,
    input  logic [nirq_pkg::KW-1:0] raddr,
    output nirq_pkg::chan_entry_t rdata
);
    import nirq_pkg::*;

    chan_entry_t mem [KEYS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the network impairment release queue: scoreboard class, stimulus tasks and top.
module tb_top;
    import nirq_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  peer;
        logic [2:0]  chan;
        logic [1:0]  mode;
        logic [15:0] tag;
        logic [47:0] rel;
        logic        last;
        logic [31:0] dropped;
        logic [31:0] delayed;
        logic [4:0]  queued;
        logic        active;
    } impair_result_t;

    class impair_scoreboard;
        logic [47:0] q_time [QUEUE_DEPTH+1];
        slot_det_t   q_det [QUEUE_DEPTH+1];
        int          q_fill;
        logic [47:0] ch_time [KEYS];
        bit          ch_vld [KEYS];
        bit          peer_blk [PEER_COUNT];
        bit          all_blk;
        logic [31:0] dropped_total;
        logic [31:0] delayed_total;
        logic [15:0] latency;
        logic [15:0] jitter;
        logic [16:0] loss;
        impair_result_t pending[$];
        int          errors;

        function new();
            q_fill = 0;
            all_blk = 0;
            dropped_total = 0;
            delayed_total = 0;
            latency = 0;
            jitter = 0;
            loss = 0;
            errors = 0;
            foreach (ch_vld[i]) ch_vld[i] = 0;
            foreach (peer_blk[i]) peer_blk[i] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] val);
            case (idx)
                REG_LATENCY: latency = val[15:0];
                REG_JITTER:  jitter = val[15:0];
                REG_LOSS:    loss = val;
                default: ;
            endcase
        endfunction

        function void drop_peer(logic [5:0] p);
            int w;
            w = 0;
            for (int i = 0; i < q_fill; i++)
                if (q_det[i].peer != p)
                begin
                    q_time[w] = q_time[i];
                    q_det[w] = q_det[i];
                    w++;
                end
            q_fill = w;
        endfunction

        function void flush_slots();
            q_fill = 0;
            foreach (ch_vld[i]) ch_vld[i] = 0;
        endfunction

        function void note_transfer(logic [2:0] cmd, logic [5:0] p, logic [2:0] ch,
                                    logic [1:0] md, logic en, logic [47:0] now,
                                    logic [15:0] ls, logic [15:0] js, logic [15:0] tag);
            impair_result_t r[$];
            impair_result_t x;
            slot_det_t d;
            logic [16:0] thr;
            logic [49:0] t;
            int idx, due, key;
            bit any_peer;
            x = '{default: 0};
            d = '{tag: tag, mode: md, chan: ch, peer: p};
            thr = (loss > 17'd65536) ? 17'd65536 : loss;
            if (cmd == CMD_ADMIT)
            begin
                x.peer = p; x.chan = ch; x.mode = md; x.tag = tag;
                if (all_blk || peer_blk[p])
                begin
                    dropped_total++;
                    x.status = STS_DROP_BLK;
                end
                else if (md == MODE_UNRELIABLE && thr != 0 && ls < thr)
                begin
                    dropped_total++;
                    x.status = STS_DROP_LOSS;
                end
                else if (latency == 0 && jitter == 0)
                begin
                    x.status = STS_PASS;
                end
                else if (q_fill >= QUEUE_DEPTH)
                begin
                    x.status = STS_FULL;
                end
                else
                begin
                    t = 50'(now) + 50'(latency) + 50'((32'(js) * 32'(jitter)) >> 16);
                    if (t > 50'hFFFFFFFFFFFF) t = 50'hFFFFFFFFFFFF;
                    if (md != MODE_UNRELIABLE)
                    begin
                        key = int'(p) * CHANNEL_COUNT + int'(ch);
                        if (ch_vld[key] && ch_time[key] > t[47:0]) t = 50'(ch_time[key]);
                        ch_time[key] = t[47:0];
                        ch_vld[key] = 1;
                    end
                    idx = q_fill;
                    while (idx > 0 && q_time[idx-1] > t[47:0])
                    begin
                        q_time[idx] = q_time[idx-1];
                        q_det[idx] = q_det[idx-1];
                        idx--;
                    end
                    q_time[idx] = t[47:0];
                    q_det[idx] = d;
                    q_fill++;
                    delayed_total++;
                    x.status = STS_HELD;
                    x.rel = t[47:0];
                end
                r = {r, x};
            end
            else if (cmd == CMD_DRAIN)
            begin
                due = 0;
                while (due < q_fill && due < MAX_OUT && q_time[due] <= now)
                begin
                    x = '{default: 0};
                    x.status = STS_RELEASED;
                    x.peer = q_det[due].peer; x.chan = q_det[due].chan;
                    x.mode = q_det[due].mode; x.tag = q_det[due].tag;
                    x.rel = q_time[due];
                    r = {r, x};
                    due++;
                end
                if (due == 0)
                begin
                    x = '{default: 0};
                    x.status = STS_DONE;
                    r = {r, x};
                end
                else
                begin
                    for (int i = 0; i < q_fill - due; i++)
                    begin
                        q_time[i] = q_time[i+due];
                        q_det[i] = q_det[i+due];
                    end
                    q_fill -= due;
                end
            end
            else
            begin
                if (cmd == CMD_PEER_BLOCK)
                begin
                    peer_blk[p] = en;
                    if (en) drop_peer(p);
                end
                else if (cmd == CMD_FORGET)
                begin
                    peer_blk[p] = 0;
                    drop_peer(p);
                    for (int c = 0; c < CHANNEL_COUNT; c++)
                        ch_vld[int'(p)*CHANNEL_COUNT+c] = 0;
                end
                else if (cmd == CMD_ALL_BLOCK)
                begin
                    all_blk = en;
                    if (en) flush_slots();
                end
                else if (cmd == CMD_CLEAR)
                begin
                    flush_slots();
                end
                x.status = STS_DONE;
                r = {r, x};
            end
            any_peer = 0;
            foreach (peer_blk[i]) if (peer_blk[i]) any_peer = 1;
            foreach (r[k])
            begin
                r[k].last = (k == r.size() - 1);
                r[k].dropped = dropped_total;
                r[k].delayed = delayed_total;
                r[k].queued = 5'(q_fill);
                r[k].active = latency != 0 || jitter != 0 || loss != 0 || all_blk || any_peer
                    || q_fill != 0;
                pending = {pending, r[k]};
            end
        endfunction

        function void check_result(impair_result_t a, logic [31:0] din);
            impair_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result status=%0d", a.status);
                return;
            end
            e = pending.pop_front();
            if (a !== e || din !== 32'd0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp=%p act=%p dropped_in=%0d", e, a, din);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [5:0]  peer;
    logic [2:0]  channel;
    logic [1:0]  transfer_mode;
    logic        enable;
    logic [47:0] now_ms;
    logic [15:0] loss_sample;
    logic [15:0] jitter_sample;
    logic [15:0] packet_tag;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [5:0]  out_peer;
    logic [2:0]  out_channel;
    logic [1:0]  out_mode;
    logic [15:0] out_tag;
    logic [47:0] release_ms;
    logic        last;
    logic [31:0] dropped_out_count;
    logic [31:0] dropped_in_count;
    logic [31:0] delayed_count;
    logic [4:0]  queued_count;
    logic        active;

    impair_scoreboard sb;
    logic [47:0] clock_ms;
    bit          stall_busy;

    network_impairment_release_queue_unit uut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("tb_top NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result('{status, out_peer, out_channel, out_mode, out_tag, release_ms,
                              last, dropped_out_count, delayed_count, queued_count, active},
                            dropped_in_count);
    end

    initial
    begin
        int w;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            if (stall_busy) w = 0;
            else w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (w > 0)
            begin
                out_stall <= 1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic send(logic [2:0] cmd, logic [5:0] p, logic [2:0] ch, logic [1:0] md,
                        logic en, logic [47:0] now, logic [15:0] ls, logic [15:0] js,
                        logic [15:0] tag, bit gap);
        int w;
        w = (gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 16) : 0;
        if (w > 0)
        begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1;
        command <= cmd; peer <= p; channel <= ch; transfer_mode <= md; enable <= en;
        now_ms <= now; loss_sample <= ls; jitter_sample <= js; packet_tag <= tag;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_transfer(cmd, p, ch, md, en, now, ls, js, tag);
    endtask

    task automatic send_ctl(logic [2:0] cmd, logic [5:0] p, logic en, logic [47:0] now);
        send(cmd, p, 3'd0, 2'd0, en, now, 16'd0, 16'd0, 16'd0, 1'b0);
    endtask

    task automatic send_random(int phase);
        int k;
        logic [2:0] cmd;
        logic [47:0] now;
        k = $urandom_range(0, 99);
        if (k < 55) cmd = CMD_ADMIT;
        else if (k < 80) cmd = CMD_DRAIN;
        else if (k < 86) cmd = CMD_PEER_BLOCK;
        else if (k < 91) cmd = CMD_FORGET;
        else if (k < 94) cmd = CMD_ALL_BLOCK;
        else if (k < 97) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(6, 7));
        clock_ms = clock_ms + 48'($urandom_range(0, 3000));
        now = clock_ms;
        if (phase == 3 && $urandom_range(0, 7) == 0) now = 48'({$urandom, $urandom});
        send(cmd, 6'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3)),
             3'($urandom), 2'($urandom), ($urandom_range(0, 3) != 0) ^ (cmd == CMD_ALL_BLOCK),
             now, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    endtask

    initial
    begin
        sb = new();
        clock_ms = 0;
        stall_busy = 0;
        rst_n = 0;
        cfg_write = 0; cfg_index = 0; cfg_data = 0;
        in_valid = 0;
        command = 0; peer = 0; channel = 0; transfer_mode = 0; enable = 0;
        now_ms = 0; loss_sample = 0; jitter_sample = 0; packet_tag = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        repeat (600) @(posedge clk);

        send(CMD_ADMIT, 6'd63, 3'd7, 2'd3, 1'b1, 48'hFFFFFFFFFFFF, 16'hFFFF, 16'hFFFF,
             16'hFFFF, 1'b0);
        send_ctl(CMD_DRAIN, 6'd0, 1'b0, 48'd0);
        send_ctl(3'd6, 6'd0, 1'b0, 48'd0);
        send_ctl(3'd7, 6'd0, 1'b1, 48'd0);
        wait_idle();
        write_reg(REG_LATENCY, 17'd65535);
        write_reg(REG_JITTER, 17'd65535);
        write_reg(REG_LOSS, 17'h1FFFF);
        send(CMD_ADMIT, 6'd1, 3'd2, 2'd0, 1'b0, 48'd100, 16'hFFFF, 16'd0, 16'h1234, 1'b0);
        send(CMD_ADMIT, 6'd1, 3'd2, 2'd1, 1'b0, 48'hFFFFFFFFFF00, 16'd0, 16'hFFFF, 16'hABCD,
             1'b0);
        send(CMD_ADMIT, 6'd1, 3'd2, 2'd2, 1'b0, 48'd10, 16'd0, 16'd0, 16'h0001, 1'b0);
        for (int i = 0; i < 16; i++)
            send(CMD_ADMIT, 6'(i), 3'(i), 2'd2, 1'b0, 48'(i * 7), 16'd0, 16'($urandom),
                 16'(i), 1'b0);
        send_ctl(CMD_DRAIN, 6'd0, 1'b0, 48'hFFFFFFFFFFFF);
        send_ctl(CMD_DRAIN, 6'd0, 1'b0, 48'hFFFFFFFFFFFF);
        send_ctl(CMD_PEER_BLOCK, 6'd5, 1'b1, 48'd0);
        send(CMD_ADMIT, 6'd5, 3'd0, 2'd2, 1'b0, 48'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_ctl(CMD_FORGET, 6'd5, 1'b0, 48'd0);
        send_ctl(CMD_ALL_BLOCK, 6'd0, 1'b1, 48'd0);
        send(CMD_ADMIT, 6'd0, 3'd0, 2'd2, 1'b0, 48'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_ctl(CMD_ALL_BLOCK, 6'd0, 1'b0, 48'd0);
        send_ctl(CMD_CLEAR, 6'd0, 1'b0, 48'd0);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_LATENCY, 17'd0); write_reg(REG_JITTER, 17'd0);
                    write_reg(REG_LOSS, 17'd65536);
                end
                1:
                begin
                    write_reg(REG_LATENCY, 17'd500); write_reg(REG_JITTER, 17'd2000);
                    write_reg(REG_LOSS, 17'd16384);
                end
                2:
                begin
                    write_reg(REG_LATENCY, 17'd0); write_reg(REG_JITTER, 17'd4000);
                    write_reg(REG_LOSS, 17'd0);
                end
                default:
                begin
                    write_reg(REG_LATENCY, 17'd65535);
                    write_reg(REG_JITTER, 17'd65535); write_reg(REG_LOSS, 17'd1);
                end
            endcase
            stall_busy = (ph == 2);
            for (int i = 0; i < 75; i++) send_random(ph);
            send_ctl(CMD_DRAIN, 6'd0, 1'b0, 48'hFFFFFFFFFFFF);
            send_ctl(CMD_CLEAR, 6'd0, 1'b0, 48'd0);
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

/* filelist.f */
sv/nirq_pkg.sv
sv/nirq_chan_mem.sv
sv/network_impairment_release_queue_unit.sv
tb/sv/tb_top.sv
